FILE: sv/spheroid_pixel_scale_macros.svh
// Assertion macros for the spheroid pixel scale block
`ifndef SPHEROID_PIXEL_SCALE_MACROS_SVH
`define SPHEROID_PIXEL_SCALE_MACROS_SVH
`ifndef ASSERT_OFF
`define SPS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spheroid_pixel_scale: check failed");
`define SPS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spheroid_pixel_scale: check failed");
`else
`define SPS_ASSERT_SAME(label, ante, cons)
`define SPS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/sps_pkg.sv
// Shared constants, types and tables for the spheroid pixel scale block
`default_nettype none
package sps_pkg;

    localparam int ANGLE_FRAC_BITS   = 20;
    localparam int CORDIC_ITERATIONS = 24;

    localparam int RADIUS_W    = 25;
    localparam int LAT_W       = 28;
    localparam int LON_W       = 29;
    localparam int SCALE_W     = 40;
    localparam int IN_DATA_W   = 120;
    localparam int OUT_DATA_W  = 40;
    localparam int CFG_INDEX_W = 2;

    localparam int ANG_W  = 28;
    localparam int ZIN_W  = 31;
    localparam int Z_W    = 34;
    localparam int TRIG_W = 31;
    localparam int DLAT_W = 33;
    localparam int DLON_W = 32;
    localparam int DEG_W  = 27;
    localparam int GCR_W  = 63;
    localparam int DEN_W  = 32;
    localparam int LEG_W  = 41;
    localparam int K_W    = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_EQUATORIAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POLAR      = 2'd1;

    localparam logic [RADIUS_W-1:0] EQUATORIAL_RESET = 25'd1632256;
    localparam logic [RADIUS_W-1:0] POLAR_RESET      = 25'd1626624;

    localparam logic [DEG_W-1:0]      DEG_TO_RAD_Q32  = 27'd74961321;
    localparam logic signed [Z_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
    localparam logic [TRIG_W-1:0]     ONE_Q30         = 31'h4000_0000;
    localparam logic [LEG_W-1:0]      LEG_CAP         = 41'h100_0000_0000;
    localparam logic [SCALE_W-1:0]    OUT_MAX         = 40'hFF_FFFF_FFFF;

    localparam logic [29:0] FULL2 = 30'(360 << (ANGLE_FRAC_BITS + 1));
    localparam logic [28:0] FULL1 = 29'(360 << ANGLE_FRAC_BITS);

    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h3243F6A8;
            1:  r = 32'h1DAC6705;
            2:  r = 32'h0FADBAFC;
            3:  r = 32'h07F56EA6;
            4:  r = 32'h03FEAB76;
            5:  r = 32'h01FFD55B;
            6:  r = 32'h00FFFAAA;
            7:  r = 32'h007FFF55;
            8:  r = 32'h003FFFEA;
            9:  r = 32'h001FFFFD;
            10: r = 32'h000FFFFF;
            11: r = 32'h0007FFFF;
            12: r = 32'h0003FFFF;
            13: r = 32'h0001FFFF;
            14: r = 32'h0000FFFF;
            15: r = 32'h00007FFF;
            16: r = 32'h00003FFF;
            17: r = 32'h00001FFF;
            18: r = 32'h00000FFF;
            19: r = 32'h000007FF;
            20: r = 32'h000003FF;
            21: r = 32'h000001FF;
            22: r = 32'h000000FF;
            23: r = 32'h0000007F;
            24: r = 32'h0000003F;
            25: r = 32'h0000001F;
            26: r = 32'h0000000F;
            27: r = 32'h00000007;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: sv/sps_cordic.sv
// Pipelined rotation CORDIC: cos and sin magnitudes of a first-quadrant angle
`default_nettype none
module sps_cordic #(
    parameter int ITERATIONS = sps_pkg::CORDIC_ITERATIONS,
    parameter int SIDE_W     = 1
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire sps_pkg::pipe_ctl_t        ctl,
    input  wire logic [sps_pkg::ZIN_W-1:0] angle,
    input  wire logic [SIDE_W-1:0]         side_in,
    output logic                           valid_out,
    output logic [sps_pkg::TRIG_W-1:0]     cos_out,
    output logic [sps_pkg::TRIG_W-1:0]     sin_out,
    output logic [SIDE_W-1:0]              side_out
);
    import sps_pkg::*;

    logic signed [Z_W-1:0] x_reg [0:ITERATIONS];
    logic signed [Z_W-1:0] y_reg [0:ITERATIONS];
    logic signed [Z_W-1:0] z_reg [0:ITERATIONS];
    logic [SIDE_W-1:0]     side_reg [0:ITERATIONS];
    logic                  v_reg [0:ITERATIONS];

    logic                  vo_reg;
    logic [TRIG_W-1:0]     c_reg;
    logic [TRIG_W-1:0]     s_reg;
    logic [SIDE_W-1:0]     so_reg;

    logic [Z_W-1:0]        xa;
    logic [Z_W-1:0]        ya;
    logic [TRIG_W-1:0]     c_next;
    logic [TRIG_W-1:0]     s_next;

    always_comb
    begin
        xa = x_reg[ITERATIONS][Z_W-1] ? Z_W'(-x_reg[ITERATIONS]) : x_reg[ITERATIONS];
        ya = y_reg[ITERATIONS][Z_W-1] ? Z_W'(-y_reg[ITERATIONS]) : y_reg[ITERATIONS];
        c_next = (xa > Z_W'(ONE_Q30)) ? ONE_Q30 : xa[TRIG_W-1:0];
        s_next = (ya > Z_W'(ONE_Q30)) ? ONE_Q30 : ya[TRIG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ITERATIONS; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            vo_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
            for (int k = 0; k < ITERATIONS; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            vo_reg <= v_reg[ITERATIONS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            x_reg[0]    <= CORDIC_GAIN_Q30;
            y_reg[0]    <= '0;
            z_reg[0]    <= $signed(Z_W'(angle));
            side_reg[0] <= side_in;
            for (int k = 0; k < ITERATIONS; k++)
            begin
                if (!z_reg[k][Z_W-1])
                begin
                    x_reg[k+1] <= x_reg[k] - (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] + (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] - $signed(Z_W'(atan_q30(k)));
                end
                else
                begin
                    x_reg[k+1] <= x_reg[k] + (y_reg[k] >>> k);
                    y_reg[k+1] <= y_reg[k] - (x_reg[k] >>> k);
                    z_reg[k+1] <= z_reg[k] + $signed(Z_W'(atan_q30(k)));
                end
                side_reg[k+1] <= side_reg[k];
            end
            c_reg  <= c_next;
            s_reg  <= s_next;
            so_reg <= side_reg[ITERATIONS];
        end
    end

    assign valid_out = vo_reg;
    assign cos_out   = c_reg;
    assign sin_out   = s_reg;
    assign side_out  = so_reg;

endmodule
`default_nettype wire

FILE: sv/sps_isqrt.sv
// Pipelined floor square root, one root bit per stage
`default_nettype none
module sps_isqrt #(
    parameter int ROOT_W = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sps_pkg::pipe_ctl_t    ctl,
    input  wire logic [2*ROOT_W-1:0]   radicand,
    input  wire logic [SIDE_W-1:0]     side_in,
    output logic                       valid_out,
    output logic [ROOT_W-1:0]          root_out,
    output logic [SIDE_W-1:0]          side_out
);
    import sps_pkg::*;

    logic [2*ROOT_W-1:0] rad_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   rem_reg  [0:ROOT_W];
    logic [ROOT_W-1:0]   root_reg [0:ROOT_W];
    logic [SIDE_W-1:0]   side_reg [0:ROOT_W];
    logic                v_reg    [0:ROOT_W];

    logic [ROOT_W+1:0]   rem_sh [0:ROOT_W-1];
    logic [ROOT_W+1:0]   trial  [0:ROOT_W-1];

    always_comb
    begin
        for (int k = 0; k < ROOT_W; k++)
        begin
            rem_sh[k] = {rem_reg[k], rad_reg[k][2*ROOT_W-1 -: 2]};
            trial[k]  = {root_reg[k], 2'b01};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= ROOT_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
            for (int k = 0; k < ROOT_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rad_reg[0]  <= radicand;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            side_reg[0] <= side_in;
            for (int k = 0; k < ROOT_W; k++)
            begin
                if (rem_sh[k] >= trial[k])
                begin
                    rem_reg[k+1]  <= ROOT_W'(rem_sh[k] - trial[k]);
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= rem_sh[k][ROOT_W-1:0];
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
                end
                rad_reg[k+1]  <= rad_reg[k] << 2;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign valid_out = v_reg[ROOT_W];
    assign root_out  = root_reg[ROOT_W];
    assign side_out  = side_reg[ROOT_W];

endmodule
`default_nettype wire

FILE: sv/sps_div.sv
// Pipelined restoring divider, one quotient bit per stage; zero divisor gives zero
`default_nettype none
module sps_div #(
    parameter int NUM_W  = 63,
    parameter int DEN_W  = 32,
    parameter int SIDE_W = 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sps_pkg::pipe_ctl_t  ctl,
    input  wire logic [NUM_W-1:0]    numerator,
    input  wire logic [DEN_W-1:0]    denominator,
    input  wire logic [SIDE_W-1:0]   side_in,
    output logic                     valid_out,
    output logic [NUM_W-1:0]         quotient,
    output logic [SIDE_W-1:0]        side_out
);
    import sps_pkg::*;

    logic [NUM_W-1:0]  num_reg  [0:NUM_W];
    logic [DEN_W-1:0]  rem_reg  [0:NUM_W];
    logic [DEN_W-1:0]  den_reg  [0:NUM_W];
    logic [SIDE_W-1:0] side_reg [0:NUM_W];
    logic              v_reg    [0:NUM_W];

    logic              vo_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [SIDE_W-1:0] so_reg;

    logic [DEN_W:0]    rem_sh [0:NUM_W-1];

    always_comb
    begin
        for (int k = 0; k < NUM_W; k++)
        begin
            rem_sh[k] = {rem_reg[k], num_reg[k][NUM_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NUM_W; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            vo_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v_reg[0] <= ctl.valid;
            for (int k = 0; k < NUM_W; k++)
            begin
                v_reg[k+1] <= v_reg[k];
            end
            vo_reg <= v_reg[NUM_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            num_reg[0]  <= numerator;
            rem_reg[0]  <= '0;
            den_reg[0]  <= denominator;
            side_reg[0] <= side_in;
            for (int k = 0; k < NUM_W; k++)
            begin
                if (rem_sh[k] >= {1'b0, den_reg[k]})
                begin
                    rem_reg[k+1] <= DEN_W'(rem_sh[k] - {1'b0, den_reg[k]});
                    num_reg[k+1] <= {num_reg[k][NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1] <= rem_sh[k][DEN_W-1:0];
                    num_reg[k+1] <= {num_reg[k][NUM_W-2:0], 1'b0};
                end
                den_reg[k+1]  <= den_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
            q_reg  <= (den_reg[NUM_W] == '0) ? '0 : num_reg[NUM_W];
            so_reg <= side_reg[NUM_W];
        end
    end

    assign valid_out = vo_reg;
    assign quotient  = q_reg;
    assign side_out  = so_reg;

endmodule
`default_nettype wire

FILE: sv/spheroid_pixel_scale.sv
// Top level: surface distance in meters between two points on an oblate spheroid.
// Throughput: one point pair per cycle while the skid entry is empty, set by the fully
// pipelined CORDIC, root and divider; all stages stall while the skid entry is full.
// Reset: radii return to 6376 km and 6354 km, all pipeline and output valids clear.
`default_nettype none
`include "spheroid_pixel_scale_macros.svh"
module spheroid_pixel_scale #(
    parameter int CORDIC_ITERATIONS = sps_pkg::CORDIC_ITERATIONS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // first_latitude, first_longitude, second_latitude, second_longitude, zero fill
    input  wire logic [sps_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // scale_meters
    output logic [sps_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [sps_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [sps_pkg::RADIUS_W-1:0]    cfg_data
);
    import sps_pkg::*;

    localparam int SIDE1_W = DLAT_W + DLON_W;
    localparam int SIDE2_W = 50 + TRIG_W + DLAT_W + DLON_W;
    localparam int SIDE3_W = TRIG_W + DLAT_W + DLON_W;

    logic [RADIUS_W-1:0] re_reg;
    logic [RADIUS_W-1:0] rp_reg;

    logic       en;
    logic       v_reg [1:15];
    pipe_ctl_t  cor_ctl;
    pipe_ctl_t  sq1_ctl;
    pipe_ctl_t  div_ctl;
    pipe_ctl_t  sq2_ctl;

    // stage 1
    logic [LAT_W-1:0] lat1_reg;
    logic [LON_W-1:0] lon1_reg;
    logic [LAT_W-1:0] lat2_reg;
    logic [LON_W-1:0] lon2_reg;
    // stage 2
    logic signed [LAT_W:0] lat_sum;
    logic signed [LAT_W:0] lat_diff;
    logic [LAT_W:0]        lat_abs;
    logic [29:0]           a_mod;
    logic [LON_W-1:0]      lon_diff;
    logic [ANG_W-1:0]      a_reg;
    logic [ANG_W-1:0]      dlat_reg;
    logic [ANG_W-1:0]      dlon_reg;
    // stage 3
    logic [ANG_W+DEG_W-1:0] pa;
    logic [ANG_W+DEG_W-1:0] pla;
    logic [ANG_W+DEG_W-1:0] plo;
    logic [ZIN_W-1:0]       z_reg;
    logic [DLAT_W-1:0]      dlr_reg;
    logic [DLON_W-1:0]      dlo_reg;
    // cordic
    logic               cor_v;
    logic [TRIG_W-1:0]  cor_c;
    logic [TRIG_W-1:0]  cor_s;
    logic [SIDE1_W-1:0] cor_side;
    // stage 4
    logic [RADIUS_W+TRIG_W-1:0] pu;
    logic [RADIUS_W+TRIG_W-1:0] pv;
    logic [31:0]         u_reg;
    logic [31:0]         w_reg;
    logic [49:0]         rr4_reg;
    logic [TRIG_W-1:0]   c4_reg;
    logic [DLAT_W-1:0]   dl4_reg;
    logic [DLON_W-1:0]   do4_reg;
    // stage 5
    logic [61:0]         uu_reg;
    logic [61:0]         ww_reg;
    logic [49:0]         rr5_reg;
    logic [TRIG_W-1:0]   c5_reg;
    logic [DLAT_W-1:0]   dl5_reg;
    logic [DLON_W-1:0]   do5_reg;
    // stage 6
    logic [62:0]         ss6_reg;
    logic [49:0]         rr6_reg;
    logic [TRIG_W-1:0]   c6_reg;
    logic [DLAT_W-1:0]   dl6_reg;
    logic [DLON_W-1:0]   do6_reg;
    // root of u^2+v^2
    logic               sq1_v;
    logic [DEN_W-1:0]   den;
    logic [SIDE2_W-1:0] sq1_side;
    // divider
    logic               div_v;
    logic [GCR_W-1:0]   gcr;
    logic [SIDE3_W-1:0] div_side;
    logic [TRIG_W-1:0]  c_d;
    logic [DLAT_W-1:0]  dl_d;
    logic [DLON_W-1:0]  do_d;
    // stage 7
    logic [64:0]         p0_reg;
    logic [63:0]         p1_reg;
    logic [62:0]         q0_reg;
    logic [61:0]         q1_reg;
    logic [DLON_W-1:0]   do7_reg;
    // stage 8
    logic [95:0]         pm;
    logic [93:0]         pg;
    logic [LEG_W-1:0]    dm8_reg;
    logic [GCR_W-1:0]    g2_reg;
    logic [DLON_W-1:0]   do8_reg;
    // stage 9
    logic [63:0]         r0_reg;
    logic [62:0]         r1_reg;
    logic [LEG_W-1:0]    dm9_reg;
    // stage 10
    logic [94:0]         pz;
    logic [LEG_W-1:0]    dm10_reg;
    logic [LEG_W-1:0]    dz10_reg;
    // stage 11
    logic [LEG_W-1:0]    legs_or;
    logic [K_W-1:0]      k_next;
    logic [K_W-1:0]      k11_reg;
    logic [30:0]         am_reg;
    logic [30:0]         az_reg;
    // stage 12
    logic [61:0]         am2_reg;
    logic [61:0]         az2_reg;
    logic [K_W-1:0]      k12_reg;
    // stage 13
    logic [62:0]         ss13_reg;
    logic [K_W-1:0]      k13_reg;
    // root of the leg squares
    logic                sq2_v;
    logic [31:0]         len_root;
    logic [K_W-1:0]      k_sq;
    // stage 14, 15
    logic [41:0]         d_shift;
    logic [51:0]         m1_reg;
    logic [44:0]         mq;
    logic [SCALE_W-1:0]  scale_reg;
    // output and skid
    logic                out_v_reg;
    logic                out_v_next;
    logic [SCALE_W-1:0]  out_d_reg;
    logic [SCALE_W-1:0]  out_d_next;
    logic                skid_v_reg;
    logic                skid_v_next;
    logic [SCALE_W-1:0]  skid_d_reg;
    logic [SCALE_W-1:0]  skid_d_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_reg <= EQUATORIAL_RESET;
            rp_reg <= POLAR_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_EQUATORIAL: re_reg <= cfg_data;
                REG_POLAR:      rp_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign en            = !skid_v_reg;
    assign s_axis_tready = en;

    assign cor_ctl = '{en: en, valid: v_reg[3]};
    assign sq1_ctl = '{en: en, valid: v_reg[6]};
    assign div_ctl = '{en: en, valid: sq1_v};
    assign sq2_ctl = '{en: en, valid: v_reg[13]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 15; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[1]  <= s_axis_tvalid;
            v_reg[2]  <= v_reg[1];
            v_reg[3]  <= v_reg[2];
            v_reg[4]  <= cor_v;
            v_reg[5]  <= v_reg[4];
            v_reg[6]  <= v_reg[5];
            v_reg[7]  <= div_v;
            v_reg[8]  <= v_reg[7];
            v_reg[9]  <= v_reg[8];
            v_reg[10] <= v_reg[9];
            v_reg[11] <= v_reg[10];
            v_reg[12] <= v_reg[11];
            v_reg[13] <= v_reg[12];
            v_reg[14] <= sq2_v;
            v_reg[15] <= v_reg[14];
        end
    end

    // mean latitude folded into the first quadrant, shorter longitude way
    always_comb
    begin
        lat_sum  = $signed({lat1_reg[LAT_W-1], lat1_reg}) + $signed({lat2_reg[LAT_W-1], lat2_reg});
        lat_diff = $signed({lat2_reg[LAT_W-1], lat2_reg}) - $signed({lat1_reg[LAT_W-1], lat1_reg});
        lat_abs  = lat_sum[LAT_W] ? (LAT_W+1)'(-lat_sum) : lat_sum;
        a_mod    = {1'b0, lat_abs};
        if (a_mod >= FULL2)
        begin
            a_mod = a_mod - FULL2;
        end
        if (a_mod > (FULL2 >> 1))
        begin
            a_mod = FULL2 - a_mod;
        end
        if (a_mod > (FULL2 >> 2))
        begin
            a_mod = (FULL2 >> 1) - a_mod;
        end
        lon_diff = (lon2_reg > lon1_reg) ? (lon2_reg - lon1_reg) : (lon1_reg - lon2_reg);
        if (lon_diff >= FULL1)
        begin
            lon_diff = lon_diff - FULL1;
        end
        if (lon_diff > (FULL1 >> 1))
        begin
            lon_diff = FULL1 - lon_diff;
        end
    end

    always_comb
    begin
        pa  = a_reg * DEG_TO_RAD_Q32;
        pla = dlat_reg * DEG_TO_RAD_Q32;
        plo = dlon_reg * DEG_TO_RAD_Q32;
        pu  = rp_reg * cor_c;
        pv  = re_reg * cor_s;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lat1_reg <= s_axis_tdata[27:0];
            lon1_reg <= s_axis_tdata[56:28];
            lat2_reg <= s_axis_tdata[84:57];
            lon2_reg <= s_axis_tdata[113:85];

            a_reg    <= a_mod[ANG_W-1:0];
            dlat_reg <= lat_diff[LAT_W] ? ANG_W'(-lat_diff) : ANG_W'(lat_diff);
            dlon_reg <= lon_diff[ANG_W-1:0];

            z_reg   <= ZIN_W'(pa >> (ANGLE_FRAC_BITS + 3));
            dlr_reg <= DLAT_W'(pla >> (ANGLE_FRAC_BITS + 2));
            dlo_reg <= DLON_W'(plo >> (ANGLE_FRAC_BITS + 2));

            u_reg   <= 32'(pu >> 24);
            w_reg   <= 32'(pv >> 24);
            rr4_reg <= re_reg * rp_reg;
            c4_reg  <= cor_c;
            {dl4_reg, do4_reg} <= cor_side;

            uu_reg  <= 62'(u_reg * u_reg);
            ww_reg  <= 62'(w_reg * w_reg);
            rr5_reg <= rr4_reg;
            c5_reg  <= c4_reg;
            dl5_reg <= dl4_reg;
            do5_reg <= do4_reg;

            ss6_reg <= {1'b0, uu_reg} + {1'b0, ww_reg};
            rr6_reg <= rr5_reg;
            c6_reg  <= c5_reg;
            dl6_reg <= dl5_reg;
            do6_reg <= do5_reg;
        end
    end

    sps_cordic #(
        .ITERATIONS (CORDIC_ITERATIONS),
        .SIDE_W     (SIDE1_W)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (cor_ctl),
        .angle     (z_reg),
        .side_in   ({dlr_reg, dlo_reg}),
        .valid_out (cor_v),
        .cos_out   (cor_c),
        .sin_out   (cor_s),
        .side_out  (cor_side)
    );

    sps_isqrt #(
        .ROOT_W (DEN_W),
        .SIDE_W (SIDE2_W)
    ) u_isqrt_den (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq1_ctl),
        .radicand  ({1'b0, ss6_reg}),
        .side_in   ({rr6_reg, c6_reg, dl6_reg, do6_reg}),
        .valid_out (sq1_v),
        .root_out  (den),
        .side_out  (sq1_side)
    );

    sps_div #(
        .NUM_W  (GCR_W),
        .DEN_W  (DEN_W),
        .SIDE_W (SIDE3_W)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (div_ctl),
        .numerator   ({sq1_side[SIDE2_W-1 -: 50], 13'd0}),
        .denominator (den),
        .side_in     (sq1_side[SIDE3_W-1:0]),
        .valid_out   (div_v),
        .quotient    (gcr),
        .side_out    (div_side)
    );

    assign {c_d, dl_d, do_d} = div_side;

    // meridional and zonal legs, capped at 2^40
    always_comb
    begin
        pm = {31'd0, p0_reg} + {p1_reg, 32'd0};
        pg = {31'd0, q0_reg} + {q1_reg, 32'd0};
        pz = {31'd0, r0_reg} + {r1_reg, 32'd0};
        legs_or = dm10_reg | dz10_reg;
        k_next = '0;
        for (int j = 0; j < 10; j++)
        begin
            if (legs_or[31+j])
            begin
                k_next = K_W'(j + 1);
            end
        end
        d_shift = 42'(len_root) << k_sq;
        mq = 45'(m1_reg >> 7);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= gcr[31:0] * dl_d;
            p1_reg  <= gcr[62:32] * dl_d;
            q0_reg  <= gcr[31:0] * c_d;
            q1_reg  <= gcr[62:32] * c_d;
            do7_reg <= do_d;

            dm8_reg <= (pm[95:30] > 66'(LEG_CAP)) ? LEG_CAP : pm[70:30];
            g2_reg  <= pg[92:30];
            do8_reg <= do7_reg;

            r0_reg  <= g2_reg[31:0] * do8_reg;
            r1_reg  <= g2_reg[62:32] * do8_reg;
            dm9_reg <= dm8_reg;

            dz10_reg <= (pz[94:30] > 65'(LEG_CAP)) ? LEG_CAP : pz[70:30];
            dm10_reg <= dm9_reg;

            k11_reg <= k_next;
            am_reg  <= 31'(dm10_reg >> k_next);
            az_reg  <= 31'(dz10_reg >> k_next);

            am2_reg <= am_reg * am_reg;
            az2_reg <= az_reg * az_reg;
            k12_reg <= k11_reg;

            ss13_reg <= {1'b0, am2_reg} + {1'b0, az2_reg};
            k13_reg  <= k12_reg;

            m1_reg <= d_shift * 52'd1000;

            if (mq < 45'd256)
            begin
                scale_reg <= '0;
            end
            else if (mq > 45'(OUT_MAX))
            begin
                scale_reg <= OUT_MAX;
            end
            else
            begin
                scale_reg <= mq[SCALE_W-1:0];
            end
        end
    end

    sps_isqrt #(
        .ROOT_W (32),
        .SIDE_W (K_W)
    ) u_isqrt_len (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sq2_ctl),
        .radicand  ({1'b0, ss13_reg}),
        .side_in   (k13_reg),
        .valid_out (sq2_v),
        .root_out  (len_root),
        .side_out  (k_sq)
    );

    // output register with one skid entry
    always_comb
    begin
        out_v_next  = out_v_reg;
        out_d_next  = out_d_reg;
        skid_v_next = skid_v_reg;
        skid_d_next = skid_d_reg;
        if (!out_v_reg || m_axis_tready)
        begin
            if (skid_v_reg)
            begin
                out_v_next  = 1'b1;
                out_d_next  = skid_d_reg;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_v_next = v_reg[15];
                out_d_next = scale_reg;
            end
        end
        else if (v_reg[15] && !skid_v_reg)
        begin
            skid_v_next = 1'b1;
            skid_d_next = scale_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata  = out_d_reg;

    `SPS_ASSERT_SAME(a_skid_needs_out, skid_v_reg, out_v_reg)
    `SPS_ASSERT_NEXT(a_skid_fills, out_v_reg && !m_axis_tready && v_reg[15] && !skid_v_reg, skid_v_reg)
    `SPS_ASSERT_NEXT(a_skid_drains, skid_v_reg && m_axis_tready, !skid_v_reg && out_v_reg)
    `SPS_ASSERT_SAME(a_min_meter, m_axis_tvalid && (m_axis_tdata != '0), m_axis_tdata >= 40'd256)

endmodule
`default_nettype wire

FILE: bench/tb_spheroid_pixel_scale.sv
// Testbench for spheroid_pixel_scale: directed table and random point pairs checked against a predictor
`default_nettype none
module tb_spheroid_pixel_scale;
    import sps_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = CORDIC_ITERATIONS + 200;

    typedef struct {
        logic signed [LAT_W-1:0] lat1;
        logic [LON_W-1:0]        lon1;
        logic signed [LAT_W-1:0] lat2;
        logic [LON_W-1:0]        lon2;
        bit                      typed;
        logic [SCALE_W-1:0]      meters;
    } pair_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [RADIUS_W-1:0] cfg_data = '0;

    logic [RADIUS_W-1:0] eq_radius;
    logic [RADIUS_W-1:0] po_radius;
    logic [SCALE_W-1:0] meters_due[$];
    int errors = 0;
    int cycles = 0;
    int rx_count = 0;
    int rx_seen = 0;
    int rx_stall = 0;
    bit burst = 0;
    pair_row_t rows[16];

    spheroid_pixel_scale DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned root_floor(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned mul_shift(input longint unsigned a,
                                                  input longint unsigned b, input int s);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> s;
        return (p[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
    endfunction

    function automatic longint unsigned leg_length(input longint unsigned a,
                                                   input longint unsigned b);
        int k;
        k = 0;
        while ((a >> k) >= (64'd1 << 31) || (b >> k) >= (64'd1 << 31))
            k++;
        a >>= k;
        b >>= k;
        return root_floor(a * a + b * b) << k;
    endfunction

    function automatic void rotate_trig(input longint z, output longint unsigned c,
                                        output longint unsigned s);
        longint arctan[24] = '{
            64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
            64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
            64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
            64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
            64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
        longint x, y, nx;
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_ITERATIONS; i++)
        begin
            if (z >= 0)
            begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= arctan[i];
            end
            else
            begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += arctan[i];
            end
            x = nx;
        end
        if (x < 0) x = -x;
        if (y < 0) y = -y;
        if (x > (64'sd1 << 30)) x = 64'sd1 << 30;
        if (y > (64'sd1 << 30)) y = 64'sd1 << 30;
        c = x;
        s = y;
    endfunction

    function automatic logic [SCALE_W-1:0] surface_meters(input pair_row_t p);
        longint la1, la2, sum;
        longint unsigned full2, full1, a, dlat, dlon, c, s, u, v, den, gcr, dm, dz, d, m;
        longint unsigned re, rp, lo1, lo2;
        la1 = longint'(p.lat1);
        la2 = longint'(p.lat2);
        lo1 = 64'(p.lon1);
        lo2 = 64'(p.lon2);
        re = 64'(eq_radius);
        rp = 64'(po_radius);
        full2 = 360 << (ANGLE_FRAC_BITS + 1);
        full1 = 360 << ANGLE_FRAC_BITS;
        sum = la1 + la2;
        a = (sum < 0 ? -sum : sum);
        a = a % full2;
        if (a > full2 / 2) a = full2 - a;
        if (a > full2 / 4) a = full2 / 2 - a;
        rotate_trig(longint'((a * 74961321) >> (ANGLE_FRAC_BITS + 3)), c, s);
        dlat = (la2 > la1) ? la2 - la1 : la1 - la2;
        dlat = (dlat * 74961321) >> (ANGLE_FRAC_BITS + 2);
        dlon = ((lo2 > lo1) ? lo2 - lo1 : lo1 - lo2) % full1;
        if (dlon > full1 / 2) dlon = full1 - dlon;
        dlon = (dlon * 74961321) >> (ANGLE_FRAC_BITS + 2);
        u = (rp * c) >> 24;
        v = (re * s) >> 24;
        den = root_floor(u * u + v * v);
        gcr = den ? ((re * rp) << 13) / den : 0;
        dm = mul_shift(gcr, dlat, 30);
        dz = mul_shift(mul_shift(gcr, c, 30), dlon, 30);
        if (dm > (64'd1 << 40)) dm = 64'd1 << 40;
        if (dz > (64'd1 << 40)) dz = 64'd1 << 40;
        d = leg_length(dm, dz);
        m = (d * 1000) >> 7;
        if (m < 256) m = 0;
        if (m > 64'hFF_FFFF_FFFF) m = 64'hFF_FFFF_FFFF;
        return m[SCALE_W-1:0];
    endfunction

    task automatic send_pair(input pair_row_t p);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid = 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {6'd0, p.lon2, p.lat2, p.lon1, p.lat1};
        do @(posedge clk); while (!s_axis_tready);
        meters_due.push_back(p.typed ? p.meters : surface_meters(p));
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [RADIUS_W-1:0] val);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_EQUATORIAL) eq_radius = val;
        else if (idx == REG_POLAR) po_radius = val;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic drain;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (meters_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic pair_row_t random_pair;
        pair_row_t p;
        longint la, lo;
        p.typed = 0;
        p.meters = '0;
        if ($urandom_range(0, 9) < 3)
        begin
            p.lat1 = LAT_W'($urandom);
            p.lon1 = LON_W'($urandom);
            p.lat2 = LAT_W'($urandom);
            p.lon2 = LON_W'($urandom);
        end
        else
        begin
            la = longint'($urandom_range(0, 2 * 94371840)) - 94371840;
            lo = longint'($urandom_range(0, 377487360));
            p.lat1 = LAT_W'(la);
            p.lon1 = LON_W'(lo);
            la = la + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            lo = lo + longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            if (lo < 0) lo += 377487360;
            p.lat2 = LAT_W'(la);
            p.lon2 = LON_W'(lo);
        end
        return p;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            rx_count <= rx_count + 1;
            if (meters_due.size() == 0)
            begin
                $error("scale_meters: unexpected transfer, actual %0d", m_axis_tdata);
                errors++;
            end
            else if (m_axis_tdata !== meters_due[0])
            begin
                $error("scale_meters: expected %0d, actual %0d", meters_due[0], m_axis_tdata);
                errors++;
                void'(meters_due.pop_front());
            end
            else
                void'(meters_due.pop_front());
        end
    end

    always @(negedge clk)
    begin
        if (rx_seen != rx_count)
        begin
            rx_seen = rx_count;
            rx_stall = burst ? 0 : $urandom_range(0, 14);
        end
        if (rx_stall > 0)
        begin
            m_axis_tready = 1'b0;
            rx_stall--;
        end
        else
            m_axis_tready = 1'b1;
    end

    initial
    begin
        rows = '{
            '{28'sd0, 29'd0, 28'sd0, 29'd0, 1, 40'd0},
            '{28'sd0, 29'd0, 28'sd1, 29'd0, 1, 40'd0},
            '{28'sd0, 29'd0, 28'sd1048576, 29'd0, 0, 40'd0},
            '{28'sd0, 29'd0, 28'sd0, 29'd1048576, 0, 40'd0},
            '{28'sd94371840, 29'd0, 28'sd94371840, 29'd377487360, 0, 40'd0},
            '{-28'sd94371840, 29'd0, -28'sd94371840, 29'd188743680, 0, 40'd0},
            '{28'sd94371840, 29'd0, -28'sd94371840, 29'd0, 0, 40'd0},
            '{28'sd0, 29'd1048576, 28'sd0, 29'd376438784, 0, 40'd0},
            '{28'sd0, 29'd0, 28'sd0, 29'd188743680, 0, 40'd0},
            '{28'sd0, 29'd0, 28'sd0, 29'd377487360, 0, 40'd0},
            '{28'sh7FFFFFF, 29'h1FFFFFFF, -28'sh8000000, 29'd0, 0, 40'd0},
            '{-28'sh8000000, 29'h1FFFFFFF, 28'sh7FFFFFF, 29'h1FFFFFFF, 0, 40'd0},
            '{28'sh7FFFFFF, 29'd5, 28'sh7FFFFFF, 29'd5, 1, 40'd0},
            '{28'sd47185920, 29'd1000, 28'sd47186920, 29'd2000, 0, 40'd0},
            '{-28'sd31457280, 29'd300000000, -28'sd31400000, 29'd300050000, 0, 40'd0},
            '{28'sd94371839, 29'd12345, 28'sd94371840, 29'd12346, 0, 40'd0}};
        eq_radius = EQUATORIAL_RESET;
        po_radius = POLAR_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_pair(rows[i]);
        for (int phase = 0; phase < 7; phase++)
        begin
            drain();
            case (phase)
                0:
                begin
                    write_reg(REG_EQUATORIAL, 25'd25600000);
                    write_reg(REG_POLAR, 25'd25600000);
                end
                1:
                begin
                    write_reg(REG_EQUATORIAL, 25'd0);
                    write_reg(REG_POLAR, 25'd0);
                end
                2:
                begin
                    write_reg(REG_EQUATORIAL, 25'd1632256);
                    write_reg(REG_POLAR, 25'd0);
                end
                3:
                begin
                    write_reg(REG_EQUATORIAL, 25'h1FFFFFF);
                    write_reg(REG_POLAR, 25'd1);
                    write_reg(2'd2, 25'd777);
                    write_reg(2'd3, 25'h1555555);
                end
                4:
                begin
                    write_reg(REG_EQUATORIAL, RADIUS_W'($urandom_range(0, 25600000)));
                    write_reg(REG_POLAR, RADIUS_W'($urandom_range(0, 25600000)));
                end
                5:
                begin
                    write_reg(REG_EQUATORIAL, 25'd256);
                    write_reg(REG_POLAR, 25'd1626624);
                end
                default:
                begin
                    write_reg(REG_EQUATORIAL, EQUATORIAL_RESET);
                    write_reg(REG_POLAR, POLAR_RESET);
                end
            endcase
            for (int n = 0; n < 108; n++)
            begin
                if (n % 36 == 0)
                    burst = ($urandom_range(0, 3) == 0);
                send_pair(random_pair());
            end
            burst = 0;
        end
        drain();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire
